// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define FDR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define FDR_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fdr_pkg.sv =====
// ----------------------------------------------------------------------------
// fdr_pkg
// Request and response types and status codes of the id-checked FIFO.
// ----------------------------------------------------------------------------
package fdr_pkg;

   localparam int ID_W   = 32;
   localparam int NAME_W = 64;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_DUP   = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic                     op;
      logic signed [ID_W-1:0]   rec_id;
      logic        [NAME_W-1:0] rec_name;
   } req_type;

   typedef struct packed {
      logic        [STAT_W-1:0] status;
      logic signed [ID_W-1:0]   out_id;
      logic        [NAME_W-1:0] out_name;
      logic        [OCC_W-1:0]  occupancy;
   } rsp_type;

endpackage

// ===== design/fifo_with_duplicate_id_reject.sv =====
// ----------------------------------------------------------------------------
// fifo_with_duplicate_id_reject
// Ring-buffer FIFO of id/name records that refuses a push whose id is held.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-----------------------------
//   req     | in        | req_valid/req_stall | req_type  (op, id, name)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_type  (status, id, name, occ)
//
// A push takes the request, sends each held record through the single
// id-compare unit fed by the id store read port, and then decides and writes;
// with nothing held the search is skipped. A pop takes, reads and responds.
// The next request is taken once the sequencer is back in idle, even while
// the last response still waits; a response that finds the output register
// full and stalled holds in its final state. Reset empties the queue at once;
// the record stores are not cleared, since only held slots are ever used.
// ----------------------------------------------------------------------------
module fifo_with_duplicate_id_reject
   import fdr_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int NAME_BITS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_PUSH_FIN = 3'd2;
   localparam logic [2:0] S_POP_RD   = 3'd3;
   localparam logic [2:0] S_POP_FIN  = 3'd4;

   // record stores: one write port, one registered read port
   logic [ID_W-1:0]      id_mem   [DEPTH];
   logic [NAME_BITS-1:0] name_mem [DEPTH];

   logic [2:0]           state_ff,     state_in;
   logic [PTR_W-1:0]     head_ff,      head_in;
   logic [PTR_W-1:0]     tail_ff,      tail_in;
   logic [CNT_W-1:0]     count_ff,     count_in;
   logic [PTR_W-1:0]     rd_ptr_ff,    rd_ptr_in;
   logic [CNT_W-1:0]     left_ff,      left_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   logic                 dup_ff,       dup_in;
   req_type              req_ff,       req_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff,       rsp_in;
   logic [ID_W-1:0]      id_rd_ff;
   logic [NAME_BITS-1:0] name_rd_ff;

   logic                 accept;
   logic                 out_free;
   logic                 rd_en;
   logic [PTR_W-1:0]     rd_addr;
   logic                 wr_en;
   logic                 id_match;
   logic                 dup_now;
   logic [CNT_W+OCC_W-1:0] occ_wide;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // read the scan pointer while searching, the head for a pop
   assign rd_en   = (state_ff == S_SCAN) || (state_ff == S_POP_RD);
   assign rd_addr = (state_ff == S_SCAN) ? rd_ptr_ff : head_ff;

   // the shared compare unit: last id read against the pending id
   assign id_match = cmp_valid_ff && (id_rd_ff == req_ff.rec_id);
   assign dup_now  = dup_ff || id_match;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      left_in      = left_ff;
      cmp_valid_in = cmp_valid_ff;
      dup_in       = dup_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      occ_wide     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in       = req;
               cmp_valid_in = 1'b0;
               dup_in       = 1'b0;
               rd_ptr_in    = head_ff;
               left_in      = count_ff;
               priority if (req.op == OP_POP) begin
                  state_in = S_POP_RD;
               end else if (count_ff == '0) begin
                  // nothing held: no search needed
                  state_in = S_PUSH_FIN;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // one stored id per cycle; fold in the compare of the previous read
            dup_in       = dup_now;
            cmp_valid_in = 1'b1;
            rd_ptr_in    = ring_next(rd_ptr_ff);
            left_in      = left_ff - 1'b1;
            if (left_ff == CNT_W'(1)) begin
               state_in = S_PUSH_FIN;
            end
         end

         S_PUSH_FIN: begin
            // absorb the last compare so a held cycle sees a stable verdict
            dup_in       = dup_now;
            cmp_valid_in = 1'b0;
            if (out_free) begin
               rsp_in.out_id   = '0;
               rsp_in.out_name = '0;
               priority if (dup_now) begin
                  rsp_in.status = ST_DUP;
                  occ_wide      = (CNT_W+OCC_W)'(count_ff);
               end else if (count_ff == FULL_CNT) begin
                  rsp_in.status = ST_FULL;
                  occ_wide      = (CNT_W+OCC_W)'(count_ff);
               end else begin
                  rsp_in.status = ST_OK;
                  wr_en         = 1'b1;
                  tail_in       = ring_next(tail_ff);
                  count_in      = count_ff + 1'b1;
                  occ_wide      = (CNT_W+OCC_W)'(count_in);
               end
               rsp_in.occupancy = occ_wide[OCC_W-1:0];
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end

         S_POP_RD: begin
            state_in = S_POP_FIN;
         end

         S_POP_FIN: begin
            if (out_free) begin
               if (count_ff == '0) begin
                  rsp_in.status   = ST_EMPTY;
                  rsp_in.out_id   = '0;
                  rsp_in.out_name = '0;
               end else begin
                  rsp_in.status   = ST_OK;
                  rsp_in.out_id   = signed'(id_rd_ff);
                  rsp_in.out_name = NAME_W'(name_rd_ff);
                  count_in        = count_ff - 1'b1;
                  if (count_in == '0) begin
                     // queue drained: rewind both pointers
                     head_in = '0;
                     tail_in = '0;
                  end else begin
                     head_in = ring_next(head_ff);
                  end
               end
               occ_wide         = (CNT_W+OCC_W)'(count_in);
               rsp_in.occupancy = occ_wide[OCC_W-1:0];
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         left_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         dup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rd_ptr_ff    <= rd_ptr_in;
         left_ff      <= left_in;
         cmp_valid_ff <= cmp_valid_in;
         dup_ff       <= dup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // record stores: write at the tail, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem[tail_ff]   <= req_ff.rec_id;
         name_mem[tail_ff] <= req_ff.rec_name[NAME_BITS-1:0];
      end
      if (rd_en) begin
         id_rd_ff   <= id_mem[rd_addr];
         name_rd_ff <= name_mem[rd_addr];
      end
   end

endmodule

// ===== design/fdr_checker.sv =====
// ----------------------------------------------------------------------------
// fdr_checker
// Port-level checks of the id-checked FIFO, bound to the FIFO module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdr_checker
   import fdr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp
);

   // no response may appear straight out of reset
   `FDR_ASSERT_NR(a_reset_quiet, clock, reset |=> !rsp_valid, "response right after reset")

   // a taken request keeps the input stalled while it runs
   `FDR_ASSERT(a_busy_after_take, clock, reset,
      req_valid && !req_stall |=> req_stall, "request taken while busy")

   // refused or empty operations carry no record
   `FDR_ASSERT(a_no_record, clock, reset,
      rsp_valid && (rsp.status != ST_OK) |-> (rsp.out_id == '0) && (rsp.out_name == '0),
      "record data on a refused operation")

   // an empty pop reports an empty queue
   `FDR_ASSERT(a_empty_occ, clock, reset,
      rsp_valid && (rsp.status == ST_EMPTY) |-> (rsp.occupancy == '0),
      "empty status with nonzero occupancy")

   // hold a stalled response
   `FDR_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled response changed")

endmodule

bind fifo_with_duplicate_id_reject fdr_checker u_fdr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);
